/* design/engine_fault_persistence_monitor_core_macros.svh */
// Assertion macros shared by the engine fault monitor RTL.
`ifndef ENGINE_FAULT_PERSISTENCE_MONITOR_CORE_MACROS_SVH
`define ENGINE_FAULT_PERSISTENCE_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFPM_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("engine fault monitor: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EFPM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("engine fault monitor: next-cycle check failed");

`endif

/* design/efpm_pkg.sv */
// Shared constants and codes for the engine fault persistence monitor.
package efpm_pkg;

  localparam int unsigned COUNT_CEILING_DEF = 1000000;
  localparam int unsigned CNT_W = 20;

  localparam int unsigned OVER_TEMP_W  = 11;
  localparam int unsigned LOW_OIL_W    = 10;
  localparam int unsigned HIGH_RPM_W   = 14;
  localparam int unsigned HIGH_TEMP_W  = 12;
  localparam int unsigned PERSIST_W    = 20;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [OVER_TEMP_W-1:0]        OVER_TEMP_RST  = 11'd1100;
  localparam logic [LOW_OIL_W-1:0]          LOW_OIL_RST    = 10'd100;
  localparam logic [HIGH_RPM_W-1:0]         HIGH_RPM_RST   = 14'd6000;
  localparam logic signed [HIGH_TEMP_W-1:0] HIGH_TEMP_RST  = 12'sd950;
  localparam logic [PERSIST_W-1:0]          TEMP_PERS_RST  = 20'd3;
  localparam logic [PERSIST_W-1:0]          OIL_PERS_RST   = 20'd3;
  localparam logic [PERSIST_W-1:0]          COMB_PERS_RST  = 20'd5;

  localparam logic [2:0] REG_OVER_TEMP  = 3'd0;
  localparam logic [2:0] REG_LOW_OIL    = 3'd1;
  localparam logic [2:0] REG_HIGH_RPM   = 3'd2;
  localparam logic [2:0] REG_HIGH_TEMP  = 3'd3;
  localparam logic [2:0] REG_TEMP_PERS  = 3'd4;
  localparam logic [2:0] REG_OIL_PERS   = 3'd5;
  localparam logic [2:0] REG_COMB_PERS  = 3'd6;

  localparam logic [2:0] MODE_INIT     = 3'd0;
  localparam logic [2:0] MODE_STARTING = 3'd1;
  localparam logic [2:0] MODE_RUNNING  = 3'd2;
  localparam logic [2:0] MODE_WARNING  = 3'd3;
  localparam logic [2:0] MODE_SHUTDOWN = 3'd4;

  localparam logic [1:0] RES_OK       = 2'd0;
  localparam logic [1:0] RES_WARNING  = 2'd1;
  localparam logic [1:0] RES_SHUTDOWN = 2'd2;

  typedef struct packed {
    logic [1:0] result_code;
    logic [2:0] mode_next;
    logic       shutdown_raised;
    logic       warning_raised;
  } result_t;

endpackage

/* design/engine_fault_persistence_monitor_core.sv */
// Engine fault persistence monitor: three persistence counters and the mode step.
// The counter update and compares form one registered pass, loaded as each item is accepted.
// Throughput: one item per cycle unless out_tready low holds a pending result.
// The output register frees in the same cycle it is taken, so input and output overlap.
// Reset (synchronous, active low) clears the counters and the output valid flag
// and restores every configuration register to its default value.
module engine_fault_persistence_monitor_core #(
  parameter int unsigned COUNT_CEILING = efpm_pkg::COUNT_CEILING_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // temp_tenths[15:0], oil_centibar[31:16], engine_rpm[47:32], running_flag[48],
  // mode_now[51:49], zero fill[55:52]
  input  logic [efpm_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // mode_next[2:0], result_code[4:3], shutdown_raised[5], warning_raised[6], zero fill[7]
  output logic [efpm_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [efpm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [efpm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [efpm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import efpm_pkg::*;

  `include "engine_fault_persistence_monitor_core_macros.svh"

  localparam logic [CNT_W-1:0] CEIL = CNT_W'(COUNT_CEILING);

  logic [OVER_TEMP_W-1:0]        over_temp_r;
  logic [LOW_OIL_W-1:0]          low_oil_r;
  logic [HIGH_RPM_W-1:0]         high_rpm_r;
  logic signed [HIGH_TEMP_W-1:0] high_temp_r;
  logic [PERSIST_W-1:0]          temp_pers_r;
  logic [PERSIST_W-1:0]          oil_pers_r;
  logic [PERSIST_W-1:0]          comb_pers_r;

  logic [CNT_W-1:0] temp_cnt_r, temp_cnt_nxt;
  logic [CNT_W-1:0] oil_cnt_r, oil_cnt_nxt;
  logic [CNT_W-1:0] comb_cnt_r, comb_cnt_nxt;

  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        in_acc;

  logic signed [15:0] temp;
  logic [15:0]        oil;
  logic [15:0]        rpm;
  logic               running;
  logic [2:0]         mode_in;
  logic               temp_cond, oil_cond, comb_cond;
  logic               shutdown, warning;
  logic [2:0]         mode_out;

  function automatic logic [CNT_W-1:0] persist_next(input logic cond,
                                                    input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] r;
    if (!cond) begin
      r = '0;
    end else if (cnt < CEIL) begin
      r = cnt + CNT_W'(1);
    end else begin
      r = cnt;
    end
    return r;
  endfunction

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      over_temp_r <= OVER_TEMP_RST;
      low_oil_r   <= LOW_OIL_RST;
      high_rpm_r  <= HIGH_RPM_RST;
      high_temp_r <= HIGH_TEMP_RST;
      temp_pers_r <= TEMP_PERS_RST;
      oil_pers_r  <= OIL_PERS_RST;
      comb_pers_r <= COMB_PERS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OVER_TEMP: over_temp_r <= cfg_pwdata[OVER_TEMP_W-1:0];
        REG_LOW_OIL:   low_oil_r   <= cfg_pwdata[LOW_OIL_W-1:0];
        REG_HIGH_RPM:  high_rpm_r  <= cfg_pwdata[HIGH_RPM_W-1:0];
        REG_HIGH_TEMP: high_temp_r <= $signed(cfg_pwdata[HIGH_TEMP_W-1:0]);
        REG_TEMP_PERS: temp_pers_r <= cfg_pwdata[PERSIST_W-1:0];
        REG_OIL_PERS:  oil_pers_r  <= cfg_pwdata[PERSIST_W-1:0];
        REG_COMB_PERS: comb_pers_r <= cfg_pwdata[PERSIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_OVER_TEMP: cfg_prdata = CFG_DATA_W'(over_temp_r);
      REG_LOW_OIL:   cfg_prdata = CFG_DATA_W'(low_oil_r);
      REG_HIGH_RPM:  cfg_prdata = CFG_DATA_W'(high_rpm_r);
      REG_HIGH_TEMP: cfg_prdata = CFG_DATA_W'($unsigned(high_temp_r));
      REG_TEMP_PERS: cfg_prdata = CFG_DATA_W'(temp_pers_r);
      REG_OIL_PERS:  cfg_prdata = CFG_DATA_W'(oil_pers_r);
      REG_COMB_PERS: cfg_prdata = CFG_DATA_W'(comb_pers_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign temp    = $signed(in_tdata[15:0]);
  assign oil     = in_tdata[31:16];
  assign rpm     = in_tdata[47:32];
  assign running = in_tdata[48];
  assign mode_in = in_tdata[51:49];

  assign temp_cond = temp > $signed({5'b0, over_temp_r});
  assign oil_cond  = oil < {6'b0, low_oil_r};
  assign comb_cond = (rpm >= {2'b0, high_rpm_r}) &&
                     (temp >= $signed({{4{high_temp_r[HIGH_TEMP_W-1]}}, high_temp_r}));

  assign temp_cnt_nxt = persist_next(temp_cond, temp_cnt_r);
  assign oil_cnt_nxt  = persist_next(oil_cond, oil_cnt_r);
  assign comb_cnt_nxt = persist_next(comb_cond, comb_cnt_r);

  assign shutdown = (temp_cnt_nxt >= temp_pers_r) || (oil_cnt_nxt >= oil_pers_r);
  assign warning  = comb_cnt_nxt >= comb_pers_r;

  always_comb begin
    case (mode_in)
      MODE_INIT:     mode_out = running ? MODE_STARTING : MODE_INIT;
      MODE_RUNNING:  mode_out = (shutdown || warning) ? MODE_WARNING : MODE_RUNNING;
      MODE_WARNING:  mode_out = shutdown ? MODE_SHUTDOWN : MODE_WARNING;
      default:       mode_out = mode_in;
    endcase
  end

  always_comb begin
    res_nxt.mode_next       = mode_out;
    res_nxt.shutdown_raised = shutdown;
    res_nxt.warning_raised  = warning;
    case (mode_out)
      MODE_WARNING:  res_nxt.result_code = RES_WARNING;
      MODE_SHUTDOWN: res_nxt.result_code = RES_SHUTDOWN;
      default:       res_nxt.result_code = RES_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cnt_r  <= '0;
      oil_cnt_r   <= '0;
      comb_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        temp_cnt_r  <= temp_cnt_nxt;
        oil_cnt_r   <= oil_cnt_nxt;
        comb_cnt_r  <= comb_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.warning_raised, res_r.shutdown_raised,
                       res_r.result_code, res_r.mode_next};

  `EFPM_ASSERT_IMPL(a_cnt_ceiling, clk, rst_n, 1'b1,
                    (temp_cnt_r <= CEIL) && (oil_cnt_r <= CEIL) && (comb_cnt_r <= CEIL))
  `EFPM_ASSERT_NEXT(a_cnt_hold, clk, rst_n, !in_acc,
                    $stable(temp_cnt_r) && $stable(oil_cnt_r) && $stable(comb_cnt_r))
  `EFPM_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid_r, in_tready)
  `EFPM_ASSERT_NEXT(a_valid_after_accept, clk, rst_n, in_acc, out_valid_r)

endmodule

/* tb/sv/engine_fault_persistence_monitor_core_test.sv */
// Self-checking stream testbench for the engine fault persistence monitor core.
module engine_fault_persistence_monitor_core_test;
  import efpm_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam logic [2:0] MODE_INERT_LO = 3'd5;
  localparam logic [2:0] MODE_INERT_MID = 3'd6;
  localparam logic [2:0] MODE_INERT_HI = 3'd7;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 150;
  localparam int QUIET_PHASE = 6;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0]         mode_now;
    logic               running;
    logic [15:0]        rpm;
    logic [15:0]        oil;
    logic signed [15:0] temp;
  } engine_sample_t;

  typedef struct packed {
    logic       warning;
    logic       shutdown;
    logic [1:0] code;
    logic [2:0] mode;
  } verdict_t;

  typedef struct packed {
    int         temp;
    int         oil;
    int         rpm;
    bit         run;
    logic [2:0] mode;
    bit         pinned;
    logic [2:0] x_mode;
    logic [1:0] x_code;
    bit         x_sd;
    bit         x_wr;
  } drill_row_t;

  // Columns: temp, oil, rpm, running, mode, pinned, then the pinned result fields.
  localparam drill_row_t DRILL [22] = '{
    '{0, 500, 0, 1'b1, MODE_INIT, 1'b1, MODE_STARTING, RES_OK, 1'b0, 1'b0},
    '{0, 500, 0, 1'b0, MODE_INIT, 1'b1, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{0, 500, 0, 1'b1, MODE_STARTING, 1'b1, MODE_STARTING, RES_OK, 1'b0, 1'b0},
    '{0, 500, 0, 1'b1, MODE_RUNNING, 1'b1, MODE_RUNNING, RES_OK, 1'b0, 1'b0},
    '{0, 500, 0, 1'b1, MODE_WARNING, 1'b1, MODE_WARNING, RES_WARNING, 1'b0, 1'b0},
    '{0, 500, 0, 1'b0, MODE_SHUTDOWN, 1'b1, MODE_SHUTDOWN, RES_SHUTDOWN, 1'b0, 1'b0},
    '{0, 500, 0, 1'b1, MODE_INERT_LO, 1'b1, MODE_INERT_LO, RES_OK, 1'b0, 1'b0},
    '{0, 500, 0, 1'b1, MODE_INERT_MID, 1'b1, MODE_INERT_MID, RES_OK, 1'b0, 1'b0},
    '{0, 500, 0, 1'b0, MODE_INERT_HI, 1'b1, MODE_INERT_HI, RES_OK, 1'b0, 1'b0},
    '{32767, 65535, 65535, 1'b1, MODE_RUNNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{32767, 65535, 65535, 1'b1, MODE_RUNNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{32767, 65535, 65535, 1'b1, MODE_WARNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{-32768, 0, 0, 1'b0, MODE_RUNNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{-32768, 0, 0, 1'b1, MODE_WARNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{-32768, 0, 0, 1'b1, MODE_WARNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{1100, 100, 6000, 1'b1, MODE_RUNNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{1100, 100, 6000, 1'b1, MODE_RUNNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{1100, 100, 6000, 1'b1, MODE_RUNNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{1100, 100, 6000, 1'b1, MODE_RUNNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{1100, 100, 6000, 1'b1, MODE_RUNNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{1101, 99, 5999, 1'b1, MODE_WARNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0},
    '{950, 65535, 6000, 1'b1, MODE_RUNNING, 1'b0, MODE_INIT, RES_OK, 1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  logic sample_pinned;
  verdict_t pinned_verdict;
  bit quiet_run = 1'b0;

  logic [OVER_TEMP_W-1:0]        lim_over_temp = OVER_TEMP_RST;
  logic [LOW_OIL_W-1:0]          lim_low_oil = LOW_OIL_RST;
  logic [HIGH_RPM_W-1:0]         lim_high_rpm = HIGH_RPM_RST;
  logic signed [HIGH_TEMP_W-1:0] lim_high_temp = HIGH_TEMP_RST;
  logic [PERSIST_W-1:0]          lim_temp_persist = TEMP_PERS_RST;
  logic [PERSIST_W-1:0]          lim_oil_persist = OIL_PERS_RST;
  logic [PERSIST_W-1:0]          lim_comb_persist = COMB_PERS_RST;

  logic [CNT_W-1:0] temp_run = '0;
  logic [CNT_W-1:0] oil_run = '0;
  logic [CNT_W-1:0] combined_run = '0;

  verdict_t pending_verdicts [$];
  int mismatches = 0;

  engine_fault_persistence_monitor_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("engine_fault_persistence_monitor_core_test NOT OK");
    $finish;
  end

  function automatic logic [CNT_W-1:0] persist_next(bit hold, logic [CNT_W-1:0] count);
    if (!hold) return '0;
    if (count < COUNT_CEILING_DEF) return count + 1'b1;
    return count;
  endfunction

  function automatic verdict_t fault_monitor_step(engine_sample_t s);
    int t;
    bit shut;
    bit warn;
    verdict_t v;
    t = $signed(s.temp);
    temp_run = persist_next(t > int'(lim_over_temp), temp_run);
    oil_run = persist_next(s.oil < lim_low_oil, oil_run);
    combined_run = persist_next(s.rpm >= lim_high_rpm && t >= lim_high_temp, combined_run);
    shut = temp_run >= lim_temp_persist || oil_run >= lim_oil_persist;
    warn = combined_run >= lim_comb_persist;
    v.mode = s.mode_now;
    if (v.mode == MODE_INIT && s.running) v.mode = MODE_STARTING;
    if (v.mode == MODE_RUNNING && (shut || warn)) v.mode = MODE_WARNING;
    else if (v.mode == MODE_WARNING && shut) v.mode = MODE_SHUTDOWN;
    v.code = (v.mode == MODE_WARNING) ? RES_WARNING :
             (v.mode == MODE_SHUTDOWN) ? RES_SHUTDOWN : RES_OK;
    v.shutdown = shut;
    v.warning = warn;
    return v;
  endfunction

  function automatic engine_sample_t make_sample(bit hot, bit dry, bit fast);
    engine_sample_t s;
    int t;
    int pick;
    if ($urandom_range(0, 99) < 10) begin
      s = engine_sample_t'(52'({$urandom, $urandom}));
      return s;
    end
    if (hot) t = int'(lim_over_temp) + int'($urandom_range(1, 300));
    else if (fast) t = lim_high_temp + int'($urandom_range(0, 40));
    else t = int'(lim_over_temp) - int'($urandom_range(0, 700));
    s.temp = 16'(t);
    s.oil = dry ? 16'($urandom_range(0, lim_low_oil == 0 ? 0 : lim_low_oil - 1)) :
                  16'(lim_low_oil + $urandom_range(0, 2000));
    s.rpm = fast ? 16'(lim_high_rpm + $urandom_range(0, 3000)) :
                   16'($urandom_range(0, lim_high_rpm == 0 ? 0 : lim_high_rpm - 1));
    s.running = $urandom_range(0, 3) != 0;
    pick = $urandom_range(0, 99);
    if (pick < 40) s.mode_now = MODE_RUNNING;
    else if (pick < 65) s.mode_now = MODE_WARNING;
    else if (pick < 75) s.mode_now = MODE_INIT;
    else if (pick < 85) s.mode_now = MODE_STARTING;
    else if (pick < 95) s.mode_now = MODE_SHUTDOWN;
    else s.mode_now = 3'($urandom_range(MODE_INERT_LO, MODE_INERT_HI));
    return s;
  endfunction

  task automatic report_miss(string what, int want, int got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = fault_monitor_step(engine_sample_t'(in_tdata[51:0]));
        if (sample_pinned) want = pinned_verdict;
        pending_verdicts.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = verdict_t'(out_tdata[6:0]);
        if (pending_verdicts.size() == 0) begin
          report_miss("result with no item pending", 0, got);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.mode != want.mode) report_miss("mode_next", want.mode, got.mode);
          if (got.code != want.code) report_miss("result_code", want.code, got.code);
          if (got.shutdown != want.shutdown) begin
            report_miss("shutdown_raised", want.shutdown, got.shutdown);
          end
          if (got.warning != want.warning) begin
            report_miss("warning_raised", want.warning, got.warning);
          end
        end
      end
    end
  end

  always @(posedge clk) out_tready <= quiet_run || ($urandom_range(0, 99) >= 11);

  task automatic hand_over(engine_sample_t s, bit pinned, verdict_t v);
    if (!quiet_run && $urandom_range(0, 99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, s};
    sample_pinned <= pinned;
    pinned_verdict <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [2:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_OVER_TEMP: lim_over_temp = value[OVER_TEMP_W-1:0];
      REG_LOW_OIL:   lim_low_oil = value[LOW_OIL_W-1:0];
      REG_HIGH_RPM:  lim_high_rpm = value[HIGH_RPM_W-1:0];
      REG_HIGH_TEMP: lim_high_temp = value[HIGH_TEMP_W-1:0];
      REG_TEMP_PERS: lim_temp_persist = value[PERSIST_W-1:0];
      REG_OIL_PERS:  lim_oil_persist = value[PERSIST_W-1:0];
      REG_COMB_PERS: lim_comb_persist = value[PERSIST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic scatter_thresholds();
    write_limit(REG_OVER_TEMP, $urandom_range(1, 2000));
    write_limit(REG_LOW_OIL, $urandom_range(10, 1000));
    write_limit(REG_HIGH_RPM, $urandom_range(100, 10000));
    write_limit(REG_HIGH_TEMP, int'($urandom_range(0, 2500)) - 500);
  endtask

  task automatic program_limits(int phase);
    case (phase)
      1: begin
        write_limit(REG_OVER_TEMP, 1);
        write_limit(REG_LOW_OIL, 10);
        write_limit(REG_HIGH_RPM, 100);
        write_limit(REG_HIGH_TEMP, -500);
        write_limit(REG_TEMP_PERS, 1);
        write_limit(REG_OIL_PERS, 1);
        write_limit(REG_COMB_PERS, 1);
      end
      2: begin
        write_limit(REG_OVER_TEMP, 2000);
        write_limit(REG_LOW_OIL, 1000);
        write_limit(REG_HIGH_RPM, 10000);
        write_limit(REG_HIGH_TEMP, 2000);
        write_limit(REG_TEMP_PERS, COUNT_CEILING_DEF);
        write_limit(REG_OIL_PERS, COUNT_CEILING_DEF);
        write_limit(REG_COMB_PERS, COUNT_CEILING_DEF);
      end
      3: begin
        scatter_thresholds();
        write_limit(REG_TEMP_PERS, 0);
        write_limit(REG_OIL_PERS, 0);
        write_limit(REG_COMB_PERS, 0);
      end
      4: begin
        // Oversized values are cut to the register widths; the spare index is ignored.
        write_limit(REG_OVER_TEMP, 32'hFFFF_FFFF);
        write_limit(REG_LOW_OIL, 32'hFFFF_FFFF);
        write_limit(REG_HIGH_RPM, 32'hFFFF_FFFF);
        write_limit(REG_HIGH_TEMP, 32'h0000_0800);
        write_limit(REG_TEMP_PERS, 32'hFFFF_FFFF);
        write_limit(REG_OIL_PERS, COUNT_CEILING_DEF + 1);
        write_limit(REG_COMB_PERS, 32'hFFFF_FFFF);
        write_limit(REG_SPARE, 32'h0000_0001);
      end
      default: begin
        scatter_thresholds();
        write_limit(REG_TEMP_PERS, $urandom_range(1, 8));
        write_limit(REG_OIL_PERS, $urandom_range(1, 8));
        write_limit(REG_COMB_PERS, $urandom_range(1, 8));
      end
    endcase
  endtask

  initial begin
    engine_sample_t s;
    verdict_t v;
    int served;
    int span;
    bit hot;
    bit dry;
    bit fast;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    sample_pinned <= 1'b0;
    pinned_verdict <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        program_limits(phase);
        cfg_psel <= 1'b0;
        cfg_penable <= 1'b0;
        cfg_pwrite <= 1'b0;
      end
      quiet_run <= (phase == QUIET_PHASE);
      if (phase == 0) begin
        foreach (DRILL[i]) begin
          s.temp = 16'(DRILL[i].temp);
          s.oil = 16'(DRILL[i].oil);
          s.rpm = 16'(DRILL[i].rpm);
          s.running = DRILL[i].run;
          s.mode_now = DRILL[i].mode;
          v.mode = DRILL[i].x_mode;
          v.code = DRILL[i].x_code;
          v.shutdown = DRILL[i].x_sd;
          v.warning = DRILL[i].x_wr;
          hand_over(s, DRILL[i].pinned, v);
        end
      end
      served = 0;
      while (served < PHASE_ITEMS) begin
        hot = $urandom_range(0, 99) < 30;
        dry = $urandom_range(0, 99) < 30;
        fast = $urandom_range(0, 99) < 40;
        span = $urandom_range(1, 12);
        repeat (span) begin
          if (served < PHASE_ITEMS) begin
            if (served == PHASE_ITEMS / 2) drain();
            hand_over(make_sample(hot, dry, fast), 1'b0, '0);
            served++;
          end
        end
      end
    end
    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("engine_fault_persistence_monitor_core_test OK");
    end else begin
      $display("engine_fault_persistence_monitor_core_test NOT OK");
    end
    $finish;
  end

endmodule
